### rtl/bsa_pkg.sv
// Shared constants and types for the bitmap slot allocator.
package bsa_pkg;

   localparam int CAPACITY = 64;
   localparam int PTR_W    = $clog2(CAPACITY);
   localparam int IDX_W    = 8;
   localparam int SLOT_W   = 6;

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef logic [PTR_W-1:0] ptr_type;

   typedef struct packed {
      logic rotate;
      logic set_head;
      logic clr_head;
   } ring_ctl_type;

   typedef struct packed {
      ptr_type head;
      logic    head_used;
   } ring_sts_type;

   function automatic ptr_type ptr_next(input ptr_type p);
      ptr_type nxt;
      if (p == ptr_type'(CAPACITY - 1)) begin
         nxt = '0;
      end else begin
         nxt = p + ptr_type'(1);
      end
      return nxt;
   endfunction

endpackage

### rtl/bitmap_slot_allocator.sv
// Top level of the next-fit bitmap slot allocator.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_tvalid/req_tready | tuser: cmd; tdata: slot_index
//   rsp     | out | rsp_tvalid/rsp_tready | tuser: granted; tdata: slot
//
// Flags live in a ring that rotates one slot per cycle when commanded. Allocate:
// the request is accepted, the ring is rotated to bring the hint to the head and
// scanned for a free slot, and the result is registered before rsp_tvalid rises.
// Release: the request is accepted and the ring is rotated to bring the slot to the
// head, where its flag is cleared; out-of-range releases are only accepted.
// Synchronous reset clears flags and hint. A waiting result holds the next allocate at its last scan cycle.
module bitmap_slot_allocator
   import bsa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] slot_index
   input  logic       req_tuser,   // [0] cmd
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [5:0] slot, [7:6] zero
   output logic       rsp_tuser    // [0] granted
);

   ring_ctl_type      ring_ctl;
   ring_sts_type      ring_sts;
   logic [SLOT_W-1:0] slot;

   bsa_ring u_ring (
      .clock (clock),
      .reset (reset),
      .ctl   (ring_ctl),
      .sts   (ring_sts)
   );

   bsa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_cmd     (req_tuser),
      .req_index   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_granted (rsp_tuser),
      .rsp_slot    (slot),
      .ring_ctl    (ring_ctl),
      .ring_sts    (ring_sts)
   );

   assign rsp_tdata = {2'b00, slot};

`ifndef SYNTHESIS
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 8'd0)
      else $error("refused item carries a nonzero slot");

   a_alloc_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_ALLOC |=> !req_tready)
      else $error("allocate did not start a search");

   a_ring_mutex: assert property (@(posedge clock) disable iff (reset)
      $countones({ring_ctl.rotate, ring_ctl.set_head, ring_ctl.clr_head}) <= 1)
      else $error("conflicting ring commands");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("waiting result changed");
`endif

endmodule

### rtl/bsa_ring.sv
// Circular shift ring of used flags; bit 0 holds the slot at the head pointer.
module bsa_ring
   import bsa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ring_ctl_type ctl,
   output ring_sts_type sts
);

   logic [CAPACITY-1:0] flags_ff, flags_in;
   ptr_type             head_ff, head_in;

   always_comb begin
      flags_in = flags_ff;
      head_in  = head_ff;
      if (ctl.rotate) begin
         flags_in = {flags_ff[0], flags_ff[CAPACITY-1:1]};
         head_in  = ptr_next(head_ff);
      end else if (ctl.set_head) begin
         flags_in[0] = 1'b1;
      end else if (ctl.clr_head) begin
         flags_in[0] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         head_ff  <= '0;
      end else begin
         flags_ff <= flags_in;
         head_ff  <= head_in;
      end
   end

   assign sts.head      = head_ff;
   assign sts.head_used = flags_ff[0];

endmodule

### rtl/bsa_ctrl.sv
// Sequencer: seeks the ring to a target slot, clears it on release or scans from it for a free slot, holds the result.
module bsa_ctrl
   import bsa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_cmd,
   input  logic [IDX_W-1:0]    req_index,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic                rsp_granted,
   output logic [SLOT_W-1:0]   rsp_slot,
   output ring_ctl_type        ring_ctl,
   input  ring_sts_type        ring_sts
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SEEK = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic              cmd_ff, cmd_in;
   ptr_type           target_ff, target_in;
   ptr_type           hint_ff, hint_in;
   ptr_type           count_ff, count_in;
   logic              rv_ff, rv_in;
   logic              gr_ff, gr_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              space;
   logic              in_range;
   logic [PTR_W+SLOT_W-1:0] head_ext;

   assign space    = !rv_ff || rsp_tready;
   assign in_range = {1'b0, req_index} < (IDX_W+1)'(CAPACITY);
   assign head_ext = {{SLOT_W{1'b0}}, ring_sts.head};

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      target_in = target_ff;
      hint_in   = hint_ff;
      count_in  = count_ff;
      rv_in     = rv_ff && !rsp_tready;
      gr_in     = gr_ff;
      slot_in   = slot_ff;
      ring_ctl  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_cmd;
               if (req_cmd == CMD_RELEASE) begin
                  target_in = req_index[PTR_W-1:0];
                  if (in_range) begin
                     state_in = ST_SEEK;
                  end
               end else begin
                  target_in = hint_ff;
                  state_in  = ST_SEEK;
               end
            end
         end
         ST_SEEK: begin
            if (ring_sts.head == target_ff) begin
               count_in = '0;
               if (cmd_ff == CMD_RELEASE) begin
                  ring_ctl.clr_head = 1'b1;
                  if (target_ff < hint_ff) begin
                     hint_in = target_ff;
                  end
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_SCAN;
               end
            end else begin
               ring_ctl.rotate = 1'b1;
            end
         end
         ST_SCAN: begin
            // result register is the output; hold here until it is free
            if (!ring_sts.head_used) begin
               if (space) begin
                  ring_ctl.set_head = 1'b1;
                  hint_in  = ptr_next(ring_sts.head);
                  gr_in    = 1'b1;
                  slot_in  = head_ext[SLOT_W-1:0];
                  state_in = ST_DONE;
               end
            end else if (count_ff == ptr_type'(CAPACITY - 1)) begin
               if (space) begin
                  gr_in    = 1'b0;
                  slot_in  = '0;
                  state_in = ST_DONE;
               end
            end else begin
               ring_ctl.rotate = 1'b1;
               count_in = count_ff + ptr_type'(1);
            end
         end
         ST_DONE: begin
            if (space) begin
               rv_in    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hint_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         hint_ff  <= hint_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      target_ff <= target_in;
      count_ff  <= count_in;
      gr_ff     <= gr_in;
      slot_ff   <= slot_in;
   end

   assign req_tready  = (state_ff == ST_IDLE);
   assign rsp_tvalid  = rv_ff;
   assign rsp_granted = gr_ff;
   assign rsp_slot    = slot_ff;

endmodule

### tb/tb_bitmap_slot_allocator.sv
// Self-checking testbench for the next-fit bitmap slot allocator.
`timescale 1ns / 100ps

module tb_bitmap_slot_allocator;
   import bsa_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int DRAIN_CYCLES = 300;
   localparam int NONE = -1;

   typedef struct {
      logic              granted;
      logic [SLOT_W-1:0] slot;
   } grant_type;

   class slot_ledger;
      logic [CAPACITY-1:0] taken;
      ptr_type             hint;
      grant_type           due_grants[$];
      int                  errors;

      function new();
         taken = '0;
         hint = '0;
         errors = 0;
      endfunction

      function void note_request(input logic cmd, input logic [IDX_W-1:0] idx);
         grant_type g;
         int pos;
         if (cmd == CMD_RELEASE) begin
            if (idx < CAPACITY) begin
               taken[idx] = 1'b0;
               if (idx < hint) begin
                  hint = ptr_type'(idx);
               end
            end
         end else begin
            g.granted = 1'b0;
            g.slot = '0;
            for (int i = 0; i < CAPACITY; i++) begin
               pos = (int'(hint) + i) % CAPACITY;
               if (!taken[pos]) begin
                  taken[pos] = 1'b1;
                  hint = ptr_type'((pos + 1) % CAPACITY);
                  g.granted = 1'b1;
                  g.slot = SLOT_W'(pos);
                  break;
               end
            end
            due_grants = {due_grants, g};
         end
      endfunction

      function void check_grant(input logic granted, input logic [7:0] data);
         grant_type want;
         if (due_grants.size() == 0) begin
            $error("unexpected item: granted %0d slot %0d", granted, data[5:0]);
            errors++;
            return;
         end
         want = due_grants.pop_front();
         if (granted !== want.granted) begin
            $error("granted: expected %0d, got %0d", want.granted, granted);
            errors++;
         end
         if (data[5:0] !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, data[5:0]);
            errors++;
         end
         if (data[7:6] !== 2'b00) begin
            $error("pad: expected 0, got %0d", data[7:6]);
            errors++;
         end
      endfunction

      function int pick_taken();
         int start;
         int pos;
         start = $urandom_range(CAPACITY - 1);
         for (int i = 0; i < CAPACITY; i++) begin
            pos = (start + i) % CAPACITY;
            if (taken[pos]) begin
               return pos;
            end
         end
         return NONE;
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;   // [7:0] slot_index
   logic       req_tuser = 1'b0; // [0] cmd
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;        // [5:0] slot, [7:6] zero
   logic       rsp_tuser;        // [0] granted

   slot_ledger ledger = new();
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   int         cycles = 0;

   bitmap_slot_allocator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         ledger.check_grant(rsp_tuser, rsp_tdata);
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_item(input logic cmd, input logic [7:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= idx;
      do begin
         @(posedge clock);
      end while (!req_tready);
      ledger.note_request(cmd, idx);
   endtask

   task automatic run_random(input int n_items);
      int done;
      int burst;
      int alloc_pct;
      int r;
      int pick;
      done = 0;
      while (done < n_items) begin
         case ($urandom_range(2))
            0: begin
               alloc_pct = 95;
            end
            1: begin
               alloc_pct = 55;
            end
            default: begin
               alloc_pct = 20;
            end
         endcase
         burst = $urandom_range(80, 20);
         for (int k = 0; k < burst && done < n_items; k++) begin
            if ($urandom_range(99) < alloc_pct) begin
               send_item(CMD_ALLOC, 8'($urandom_range(255)));
               done++;
            end else begin
               r = $urandom_range(99);
               pick = ledger.pick_taken();
               if (r < 12) begin
                  // out of range, ignored by the block
                  send_item(CMD_RELEASE, 8'($urandom_range(255, CAPACITY)));
               end else if (r < 30 || pick == NONE) begin
                  send_item(CMD_RELEASE, 8'($urandom_range(CAPACITY - 1)));
                  done++;
               end else begin
                  send_item(CMD_RELEASE, 8'(pick));
                  done++;
               end
            end
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(CMD_ALLOC, 8'h00);
      send_item(CMD_ALLOC, 8'hff);
      send_item(CMD_ALLOC, 8'h55);
      send_item(CMD_RELEASE, 8'd1);
      send_item(CMD_ALLOC, 8'haa);
      send_item(CMD_RELEASE, 8'd0);
      send_item(CMD_RELEASE, 8'd63);    // already free, hint unchanged
      send_item(CMD_RELEASE, 8'd64);    // out of range
      send_item(CMD_RELEASE, 8'd255);
      send_item(CMD_RELEASE, 8'd128);
      send_item(CMD_RELEASE, 8'd127);
      send_item(CMD_ALLOC, 8'h00);
      send_item(CMD_ALLOC, 8'h00);
      send_item(CMD_ALLOC, 8'h00);
      send_item(CMD_RELEASE, 8'd2);
      send_item(CMD_RELEASE, 8'd0);
      send_item(CMD_ALLOC, 8'h00);
      send_item(CMD_ALLOC, 8'h00);
      send_item(CMD_RELEASE, 8'd3);
      send_item(CMD_ALLOC, 8'h00);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 48;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 48;
            end
            default: begin
               send_idle_pct = 21;
               recv_stall_pct = 21;
            end
         endcase
         run_random(425);
      end
      req_tvalid <= 1'b0;

      while (ledger.due_grants.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (ledger.errors == 0 && ledger.due_grants.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
